/* src/ilist_pkg.sv */
// ----------------------------------------------------------------------------
// ilist_pkg: shared types and constants for the indexed list block
// Request/result structs, action and status codes, cell command format.
// ----------------------------------------------------------------------------
package ilist_pkg;

	localparam int DEPTH   = 64;
	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int POS_W   = 7;
	localparam int CAP_W   = 7;
	localparam int ENTRY_W = 7;
	localparam int DATA_W  = 32;
	localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int APB_AW  = 3;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

	typedef enum logic [0:0] {
		REG_CAPACITY = 1'b0
	} reg_idx_t;

	typedef enum logic [2:0] {
		ACT_INSERT_AT   = 3'd0,
		ACT_APPEND      = 3'd1,
		ACT_REMOVE_AT   = 3'd2,
		ACT_REMOVE_LAST = 3'd3,
		ACT_READ_AT     = 3'd4,
		ACT_PUSH_FRONT  = 3'd5,
		ACT_CLEAR       = 3'd6
	} action_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_FULL    = 2'd2,
		ST_EMPTY   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE,
		CELL_CLEAR
	} cell_op_t;

	typedef struct packed {
		logic [2:0]              action;
		logic [POS_W-1:0]        position;
		logic signed [DATA_W-1:0] item_value;
	} req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] read_value;
		logic [ENTRY_W-1:0]       entry_count;
		logic                     is_full;
		logic                     is_empty;
	} rsp_t;

	// broadcast to every cell
	typedef struct packed {
		cell_op_t                 op;
		logic [IDX_W-1:0]         pos;
		logic [CNT_W-1:0]         limit;
		logic signed [DATA_W-1:0] value;
		logic                     rd_en;
		logic [IDX_W-1:0]         rd_pos;
	} cell_cmd_t;

endpackage

/* src/indexed_list_insert_remove_top.sv */
// ----------------------------------------------------------------------------
// indexed_list_insert_remove_top: bounded ordered list of signed 32-bit entries
// Row of entry cells shifting in parallel, with a request decoder on top.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on start/request when busy is low; busy is always low, so
//   one request is taken every clock cycle.
//   Each request yields one result on result, marked by result_valid for one
//   cycle, in the cycle after the request is taken.
//   Insert, append, remove, push and clear move every cell at once in the
//   same cycle; a read selects one cell through an OR tree over the row.
//   The capacity register sits at APB byte address 0, read back on prdata;
//   write it only while no request is in flight; the block does not check it.
//   Reset clears all cells, the entry count and the result strobe, and sets
//   capacity to 64. The receiver cannot stall: results are never held.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  ilist_pkg::req_t                request,
	output logic                           result_valid,
	output ilist_pkg::rsp_t                result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ilist_pkg::APB_AW-1:0]   paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);

	localparam int DEPTH = ilist_pkg::DEPTH;

	logic [ilist_pkg::CAP_W-1:0]         cap_q;
	logic [ilist_pkg::CNT_W-1:0]         count_q;
	logic [ilist_pkg::CNT_W-1:0]         count_d;
	logic [ilist_pkg::CNT_W-1:0]         eff_cap;
	logic                                full;
	logic                                accept;
	logic                                rd_en;
	logic [1:0]                          status;
	logic [ilist_pkg::CMP_W-1:0]         pos_ext;
	logic [ilist_pkg::CMP_W-1:0]         cnt_ext;
	logic [ilist_pkg::CMP_W-1:0]         p;
	ilist_pkg::cell_cmd_t                cmd;
	ilist_pkg::rsp_t                     rsp_q;
	logic                                done_q;
	logic signed [ilist_pkg::DATA_W-1:0] rd_or;
	logic signed [ilist_pkg::DATA_W-1:0] cell_val [DEPTH];
	logic signed [ilist_pkg::DATA_W-1:0] cell_hit [DEPTH];

	assign busy   = 1'b0;
	assign pready = 1'b1;
	assign accept = start && !busy;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= ilist_pkg::CAP_RESET;
		end else if (psel && penable && pwrite && pready
			&& paddr[2] == ilist_pkg::REG_CAPACITY) begin
			cap_q <= pwdata[ilist_pkg::CAP_W-1:0];
		end
	end

	assign prdata = (paddr[2] == ilist_pkg::REG_CAPACITY) ? 32'(cap_q) : '0;

	always_comb begin
		if (cap_q == '0) begin
			eff_cap = ilist_pkg::CNT_W'(1);
		end else if (32'(cap_q) > DEPTH) begin
			eff_cap = ilist_pkg::CNT_W'(DEPTH);
		end else begin
			eff_cap = ilist_pkg::CNT_W'(cap_q);
		end
	end

	assign full    = count_q >= eff_cap;
	assign pos_ext = ilist_pkg::CMP_W'(request.position);
	assign cnt_ext = ilist_pkg::CMP_W'(count_q);

	// request decode
	always_comb begin
		cmd.op     = ilist_pkg::CELL_HOLD;
		cmd.pos    = '0;
		cmd.limit  = ilist_pkg::CNT_W'(DEPTH);
		cmd.value  = request.item_value;
		cmd.rd_en  = 1'b0;
		cmd.rd_pos = ilist_pkg::IDX_W'(request.position);
		status     = ilist_pkg::ST_OK;
		count_d    = count_q;
		rd_en      = 1'b0;
		p          = pos_ext;
		unique case (request.action)
			ilist_pkg::ACT_INSERT_AT, ilist_pkg::ACT_APPEND: begin
				p = (request.action == ilist_pkg::ACT_APPEND) ? cnt_ext : pos_ext;
				if (full) begin
					status = ilist_pkg::ST_FULL;
				end else if (p > cnt_ext) begin
					status = ilist_pkg::ST_INVALID;
				end else begin
					cmd.op  = ilist_pkg::CELL_INSERT;
					cmd.pos = ilist_pkg::IDX_W'(p);
					count_d = count_q + 1'b1;
				end
			end
			ilist_pkg::ACT_REMOVE_AT, ilist_pkg::ACT_REMOVE_LAST: begin
				p = (request.action == ilist_pkg::ACT_REMOVE_LAST) ? cnt_ext - 1'b1 : pos_ext;
				if (count_q == '0) begin
					status = ilist_pkg::ST_EMPTY;
				end else if (p >= cnt_ext) begin
					status = ilist_pkg::ST_INVALID;
				end else begin
					cmd.op  = ilist_pkg::CELL_REMOVE;
					cmd.pos = ilist_pkg::IDX_W'(p);
					count_d = count_q - 1'b1;
				end
			end
			ilist_pkg::ACT_READ_AT: begin
				if (pos_ext >= cnt_ext) begin
					status = ilist_pkg::ST_INVALID;
				end else begin
					rd_en = 1'b1;
				end
			end
			ilist_pkg::ACT_PUSH_FRONT: begin
				cmd.op  = ilist_pkg::CELL_INSERT;
				cmd.pos = '0;
				if (full) begin
					// last entry dropped
					cmd.limit = count_q;
				end else begin
					count_d = count_q + 1'b1;
				end
			end
			ilist_pkg::ACT_CLEAR: begin
				cmd.op  = ilist_pkg::CELL_CLEAR;
				count_d = '0;
			end
			default: begin
				status = ilist_pkg::ST_INVALID;
			end
		endcase
		cmd.rd_en = rd_en;
		if (!accept) begin
			cmd.op    = ilist_pkg::CELL_HOLD;
			cmd.rd_en = 1'b0;
		end
	end

	// cell row
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [ilist_pkg::DATA_W-1:0] left_val;
		logic signed [ilist_pkg::DATA_W-1:0] right_val;
		if (i == 0) begin : g_first
			assign left_val = '0;
		end else begin : g_mid_l
			assign left_val = cell_val[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_val = '0;
		end else begin : g_mid_r
			assign right_val = cell_val[i+1];
		end
		ilist_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.idx       (ilist_pkg::IDX_W'(i)),
			.cmd       (cmd),
			.left_val  (left_val),
			.right_val (right_val),
			.value     (cell_val[i]),
			.hit_val   (cell_hit[i])
		);
	end

	always_comb begin
		rd_or = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_or = rd_or | cell_hit[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.status      <= status;
			rsp_q.read_value  <= rd_or;
			rsp_q.entry_count <= ilist_pkg::ENTRY_W'(count_d);
			rsp_q.is_full     <= count_d >= eff_cap;
			rsp_q.is_empty    <= count_d == '0;
		end
	end

	assign result_valid = done_q;
	assign result       = rsp_q;

endmodule

/* src/ilist_cell.sv */
// ----------------------------------------------------------------------------
// ilist_cell: one slot of the list
// Holds one entry; loads, takes from a neighbor, clears or holds per command.
// ----------------------------------------------------------------------------
module ilist_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [ilist_pkg::IDX_W-1:0]       idx,
	input  ilist_pkg::cell_cmd_t              cmd,
	input  logic signed [ilist_pkg::DATA_W-1:0] left_val,
	input  logic signed [ilist_pkg::DATA_W-1:0] right_val,
	output logic signed [ilist_pkg::DATA_W-1:0] value,
	output logic signed [ilist_pkg::DATA_W-1:0] hit_val
);

	logic signed [ilist_pkg::DATA_W-1:0] val_q;
	logic signed [ilist_pkg::DATA_W-1:0] val_d;
	logic [ilist_pkg::CNT_W-1:0]         idx_ext;

	assign idx_ext = ilist_pkg::CNT_W'(idx);

	always_comb begin
		val_d = val_q;
		unique case (cmd.op)
			ilist_pkg::CELL_HOLD: begin
				val_d = val_q;
			end
			ilist_pkg::CELL_INSERT: begin
				if (idx == cmd.pos) begin
					val_d = cmd.value;
				end else if (idx > cmd.pos) begin
					val_d = (idx_ext < cmd.limit) ? left_val : '0;
				end
			end
			ilist_pkg::CELL_REMOVE: begin
				if (idx >= cmd.pos) begin
					val_d = right_val;
				end
			end
			ilist_pkg::CELL_CLEAR: begin
				val_d = '0;
			end
			default: begin
				val_d = val_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
		end else begin
			val_q <= val_d;
		end
	end

	assign value   = val_q;
	assign hit_val = (cmd.rd_en && idx == cmd.rd_pos) ? val_q : '0;

endmodule

/* test/indexed_list_insert_remove_top_test.sv */
// ----------------------------------------------------------------------------
// indexed_list_insert_remove_top_test: self-checking bench for the indexed list
// Drives list requests in random bursts and predicts each result from a local
// model of the list. It also sweeps the capacity register over its extremes
// through the APB port.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import ilist_pkg::*;

	localparam logic [2:0] ACT_UNUSED = 3'd7;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                start;
	logic                busy;
	req_t                request;
	logic                result_valid;
	rsp_t                result;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [APB_AW-1:0]   paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	indexed_list_insert_remove_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.result_valid (result_valid),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #2 clk = ~clk;

	// list model
	logic signed [DATA_W-1:0] list_cells [DEPTH];
	int unsigned              list_count;
	logic [CAP_W-1:0]         cap_reg;

	rsp_t pending_results [$];
	int   mismatches;
	int   burst_left;

	function automatic int unsigned effective_capacity();
		if (cap_reg == 0)
			return 1;
		if (cap_reg > DEPTH)
			return DEPTH;
		return 32'(cap_reg);
	endfunction

	function automatic void shift_in(int unsigned pos, logic signed [DATA_W-1:0] value);
		for (int i = DEPTH - 1; i > int'(pos); i--)
			list_cells[i] = list_cells[i-1];
		list_cells[pos] = value;
		list_count++;
	endfunction

	function automatic void drop_at(int unsigned pos);
		for (int unsigned i = pos; i + 1 < list_count; i++)
			list_cells[i] = list_cells[i+1];
		list_cells[list_count-1] = '0;
		list_count--;
	endfunction

	function automatic rsp_t apply_request(req_t r);
		rsp_t        rsp;
		int unsigned cap;
		int unsigned pos;
		bit          full;
		cap = effective_capacity();
		full = (list_count >= cap);
		pos = 32'(r.position);
		rsp = '0;
		rsp.status = ST_OK;
		case (r.action)
			ACT_INSERT_AT, ACT_APPEND: begin
				if (r.action == ACT_APPEND)
					pos = list_count;
				if (full)
					rsp.status = ST_FULL;
				else if (pos > list_count)
					rsp.status = ST_INVALID;
				else
					shift_in(pos, r.item_value);
			end
			ACT_REMOVE_AT, ACT_REMOVE_LAST: begin
				if (list_count == 0)
					rsp.status = ST_EMPTY;
				else begin
					if (r.action == ACT_REMOVE_LAST)
						pos = list_count - 1;
					if (pos >= list_count)
						rsp.status = ST_INVALID;
					else
						drop_at(pos);
				end
			end
			ACT_READ_AT: begin
				if (pos >= list_count)
					rsp.status = ST_INVALID;
				else
					rsp.read_value = list_cells[pos];
			end
			ACT_PUSH_FRONT: begin
				if (full)
					drop_at(list_count - 1);
				shift_in(0, r.item_value);
			end
			ACT_CLEAR: begin
				foreach (list_cells[i])
					list_cells[i] = '0;
				list_count = 0;
			end
			default: rsp.status = ST_INVALID;
		endcase
		rsp.entry_count = ENTRY_W'(list_count);
		rsp.is_full = (list_count >= cap);
		rsp.is_empty = (list_count == 0);
		return rsp;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("[%0t] mismatch %s: got %0h want %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (pending_results.size() == 0)
				report_mismatch("result with no request pending",
					32'(result.entry_count), '0);
			else begin
				rsp_t want;
				want = pending_results.pop_front();
				if (result.status !== want.status)
					report_mismatch("status", 32'(result.status), 32'(want.status));
				if (result.read_value !== want.read_value)
					report_mismatch("read_value", result.read_value, want.read_value);
				if (result.entry_count !== want.entry_count)
					report_mismatch("entry_count", 32'(result.entry_count),
						32'(want.entry_count));
				if (result.is_full !== want.is_full)
					report_mismatch("is_full", 32'(result.is_full), 32'(want.is_full));
				if (result.is_empty !== want.is_empty)
					report_mismatch("is_empty", 32'(result.is_empty), 32'(want.is_empty));
			end
		end
	end

	function automatic req_t build_request(logic [2:0] action, int unsigned pos,
			logic [31:0] value);
		req_t r;
		r.action = action;
		r.position = POS_W'(pos);
		r.item_value = value;
		return r;
	endfunction

	// one request, then burst pacing
	task automatic send_request(req_t r);
		int gap;
		start <= 1'b1;
		request <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_results.push_back(apply_request(r));
		if (burst_left > 0)
			burst_left--;
		else begin
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 12);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic read_capacity();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= APB_AW'(4 * int'(REG_CAPACITY));
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== 32'(cap_reg))
			report_mismatch("capacity readback", prdata, 32'(cap_reg));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_capacity(logic [CAP_W-1:0] value);
		wait_idle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'(4 * int'(REG_CAPACITY));
		pwdata <= {25'($urandom_range(32'h01FF_FFFF)), value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		cap_reg = value;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		read_capacity();
	endtask

	function automatic logic [31:0] random_value();
		case ($urandom_range(19))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	// grow_pct: share of inserting actions
	function automatic req_t random_request(int grow_pct);
		int unsigned roll;
		int unsigned pos;
		logic [2:0]  action;
		roll = $urandom_range(99);
		if (roll < 2)
			action = ACT_UNUSED;
		else if (roll < 5)
			action = ACT_CLEAR;
		else if (roll < 5 + grow_pct) begin
			case ($urandom_range(2))
				0: action = ACT_INSERT_AT;
				1: action = ACT_APPEND;
				default: action = ACT_PUSH_FRONT;
			endcase
		end else begin
			case ($urandom_range(2))
				0: action = ACT_REMOVE_AT;
				1: action = ACT_REMOVE_LAST;
				default: action = ACT_READ_AT;
			endcase
		end
		pos = ($urandom_range(4) == 0) ? $urandom_range(127) : $urandom_range(list_count);
		return build_request(action, pos, random_value());
	endfunction

	task automatic test_directed_actions();
		read_capacity();
		send_request(build_request(ACT_READ_AT, 0, 32'h1234_5678));
		send_request(build_request(ACT_REMOVE_AT, 0, 0));
		send_request(build_request(ACT_REMOVE_LAST, 0, 0));
		send_request(build_request(ACT_INSERT_AT, 1, 32'h0BAD_0BAD));
		send_request(build_request(ACT_APPEND, 0, 32'h7FFF_FFFF));
		send_request(build_request(ACT_APPEND, 0, 32'h8000_0000));
		send_request(build_request(ACT_INSERT_AT, 0, 32'hFFFF_FFFF));
		send_request(build_request(ACT_INSERT_AT, 3, 32'h0000_0000));
		send_request(build_request(ACT_INSERT_AT, 127, 32'h1111_1111));
		send_request(build_request(ACT_PUSH_FRONT, 0, 32'h5555_5555));
		send_request(build_request(ACT_READ_AT, 0, 0));
		send_request(build_request(ACT_READ_AT, 4, 0));
		send_request(build_request(ACT_READ_AT, 5, 0));
		send_request(build_request(ACT_READ_AT, 127, 0));
		send_request(build_request(ACT_REMOVE_AT, 2, 0));
		send_request(build_request(ACT_REMOVE_AT, 64, 0));
		send_request(build_request(ACT_REMOVE_LAST, 0, 0));
		send_request(build_request(ACT_UNUSED, 0, 32'hAAAA_AAAA));
		send_request(build_request(ACT_CLEAR, 0, 0));
		send_request(build_request(ACT_READ_AT, 0, 0));
	endtask

	task automatic test_capacity_limits();
		set_capacity(2);
		send_request(build_request(ACT_APPEND, 0, 32'hAAAA_AAAA));
		send_request(build_request(ACT_APPEND, 0, 32'h0000_0001));
		send_request(build_request(ACT_APPEND, 0, 32'h0000_0002));
		send_request(build_request(ACT_INSERT_AT, 0, 32'h0000_0003));
		send_request(build_request(ACT_PUSH_FRONT, 0, 32'h0000_0004));
		send_request(build_request(ACT_READ_AT, 1, 0));
		// lowered below count: list stays, counts as full
		set_capacity(0);
		send_request(build_request(ACT_APPEND, 0, 32'h0000_0005));
		send_request(build_request(ACT_PUSH_FRONT, 0, 32'h0000_0006));
		send_request(build_request(ACT_REMOVE_LAST, 0, 0));
		send_request(build_request(ACT_REMOVE_LAST, 0, 0));
		send_request(build_request(ACT_PUSH_FRONT, 0, 32'h0000_0007));
		send_request(build_request(ACT_CLEAR, 0, 0));
	endtask

	task automatic test_random_traffic();
		int caps [8]  = '{64, 127, 5, 0, 1, 100, 16, 64};
		int grow [8]  = '{50, 85, 40, 50, 50, 80, 50, 50};
		int items [8] = '{60, 120, 60, 50, 50, 100, 60, 60};
		for (int p = 0; p < 8; p++) begin
			set_capacity(CAP_W'(caps[p]));
			repeat (items[p])
				send_request(random_request(grow[p]));
		end
	endtask

	initial begin
		#200us;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		mismatches = 0;
		burst_left = 0;
		foreach (list_cells[i])
			list_cells[i] = '0;
		list_count = 0;
		cap_reg = CAP_RESET;
		arst_n <= 1'b0;
		start <= 1'b0;
		request <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_actions();
		test_capacity_limits();
		test_random_traffic();

		wait_idle();
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
